[design/mmt_pkg.sv]
// package for the mmio mapping tracker: sizes, operation and status codes,
// payload structs and the span overlap function; no dependencies
package mmt_pkg;

  localparam int MaxRanges   = 8;
  localparam int MaxMappings = 16;
  localparam int RangeIdxW   = $clog2(MaxRanges);
  localparam int RangeCntW   = $clog2(MaxRanges + 1);
  localparam int CellIdxW    = $clog2(MaxMappings);

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_CREATE = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_FIND   = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] virtual_address;
    logic [63:0] phys_start;
    logic [63:0] span_bytes;
    logic [63:0] range_last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_range_base;
    logic [63:0] found_virtual_address;
    logic [63:0] found_bytes;
  } out_item_t;

  // contents of one mapping cell
  typedef struct packed {
    logic                 valid;
    logic [63:0]          vaddr;
    logic [63:0]          bytes;
    logic [RangeIdxW-1:0] ridx;
  } cell_t;

  // commands broadcast from the controller to the cell chain
  typedef struct packed {
    logic                 clear;
    logic                 push;
    logic                 remove;
    logic [CellIdxW-1:0]  remove_at;
    logic [RangeIdxW-1:0] ridx;
    logic [63:0]          vaddr;
    logic [63:0]          bytes;
  } cell_cmd_t;

  // span (a, s) overlaps region (b, n)
  function automatic logic spans_overlap(logic [63:0] a, logic [63:0] s,
                                         logic [63:0] b, logic [63:0] n);
    logic [63:0] d1;
    logic [63:0] d2;
    d1 = b - a;
    d2 = a - b;
    if (a < b) return s > d1;
    return n > d2;
  endfunction

endpackage

[design/mmt_cell.sv]
// one mapping cell of the shifting chain; takes its neighbours' contents
// depends on mmt_pkg
module mmt_cell import mmt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_cmd_t           cmd,
  input  logic [CellIdxW-1:0] my_index,
  input  cell_t               from_prev,
  input  cell_t               from_next,
  output cell_t               cell_q
);

  cell_t cell_r;
  cell_t cell_nxt;

  // clear on clear, shift down on push, up from the removal point on delete
  always_comb begin
    cell_nxt = cell_r;
    if (cmd.clear) begin
      cell_nxt.valid = 1'b0;
    end else if (cmd.push) begin
      if (my_index == '0) begin
        cell_nxt.valid = 1'b1;
        cell_nxt.vaddr = cmd.vaddr;
        cell_nxt.bytes = cmd.bytes;
        cell_nxt.ridx  = cmd.ridx;
      end else begin
        cell_nxt = from_prev;
      end
    end else if (cmd.remove && my_index >= cmd.remove_at) begin
      cell_nxt = from_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
    cell_r.vaddr <= cell_nxt.vaddr;
    cell_r.bytes <= cell_nxt.bytes;
    cell_r.ridx  <= cell_nxt.ridx;
  end

  assign cell_q = cell_r;

endmodule

[design/mmt_chain.sv]
// row of mapping cells, newest in cell 0, valid cells packed as a prefix
// depends on mmt_pkg and mmt_cell
module mmt_chain import mmt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  output cell_t     cells [MaxMappings]
);

  cell_t empty_cell;

  assign empty_cell = '0;

  // neighbour links; the last cell pulls in an empty cell
  for (genvar i = 0; i < MaxMappings; i++) begin : g_cell
    cell_t prev_c;
    cell_t next_c;
    if (i == 0) begin : g_first
      assign prev_c = empty_cell;
    end else begin : g_mid
      assign prev_c = cells[i-1];
    end
    if (i == MaxMappings - 1) begin : g_last
      assign next_c = empty_cell;
    end else begin : g_inner
      assign next_c = cells[i+1];
    end
    mmt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .my_index  (CellIdxW'(i)),
      .from_prev (prev_c),
      .from_next (next_c),
      .cell_q    (cells[i])
    );
  end

endmodule

[design/mmio_mapping_tracker.sv]
// top level of the mmio mapping tracker: range table, sequencer, cell chain
// depends on mmt_pkg and mmt_chain
module mmio_mapping_tracker import mmt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  // One transaction at a time. add_range and unused codes offer their result
  // in the cycle after acceptance; clear goes through the apply state to the
  // result state. map_create scans the range table, one range a cycle (up to 8),
  // then pushes into the cell chain. map_delete and map_find walk the ranges in
  // order and, per range, up to 16 mapping cells one a cycle, stopping at the
  // first empty cell; a walk stops at the first hit. The result register frees
  // the input once it is taken.

  typedef enum logic [2:0] {S_IDLE, S_RSCAN, S_CSCAN, S_APPLY, S_OUT} state_t;

  state_t               state_r;
  in_item_t             item_r;
  logic [RangeCntW-1:0] rcount_r;
  logic [RangeIdxW-1:0] ridx_r;
  logic [CellIdxW-1:0]  cidx_r;
  logic [63:0]          rbase   [MaxRanges];
  logic [63:0]          rbytes  [MaxRanges];
  out_item_t            res_r;
  cell_cmd_t            cmd;
  cell_t                cells [MaxMappings];
  cell_t                cur_cell;
  logic [63:0]          cur_base;
  logic [63:0]          cur_bytes;
  logic [64:0]          diff;
  logic [63:0]          new_bytes;
  logic                 range_hit;
  logic                 cell_hit;
  logic                 last_cell;
  logic                 last_range;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;

  assign cur_cell  = cells[cidx_r];
  assign cur_base  = rbase[ridx_r];
  assign cur_bytes = rbytes[ridx_r];
  assign range_hit = spans_overlap(item_r.phys_start, item_r.span_bytes,
                                   cur_base, cur_bytes);
  assign cell_hit  = cur_cell.valid && cur_cell.ridx == ridx_r &&
                     spans_overlap(item_r.virtual_address, item_r.span_bytes,
                                   cur_cell.vaddr, cur_cell.bytes);
  assign last_cell  = (cidx_r == CellIdxW'(MaxMappings - 1));
  assign last_range = ({1'b0, ridx_r} + 1'b1 >= (RangeIdxW+1)'(rcount_r));

  // range length, zero for a reversed range, with the whole-space case saturated
  assign diff = {1'b0, in_data.range_last_byte} - {1'b0, in_data.phys_start};
  always_comb begin
    if (in_data.range_last_byte < in_data.phys_start) begin
      new_bytes = '0;
    end else if (&diff[63:0]) begin
      new_bytes = diff[63:0];
    end else begin
      new_bytes = diff[63:0] + 64'd1;
    end
  end

  // chain commands, issued in the apply state
  always_comb begin
    cmd           = '0;
    cmd.ridx      = ridx_r;
    cmd.vaddr     = item_r.virtual_address;
    cmd.bytes     = item_r.span_bytes;
    cmd.remove_at = cidx_r;
    if (state_r == S_APPLY) begin
      case (item_r.operation)
        OP_CLEAR:  cmd.clear  = 1'b1;
        OP_CREATE: cmd.push   = 1'b1;
        OP_DELETE: cmd.remove = 1'b1;
        default:   cmd.push   = 1'b0;
      endcase
    end
  end

  mmt_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .cells (cells)
  );

  // range table writes
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && in_data.operation == OP_ADD &&
        rcount_r < RangeCntW'(MaxRanges)) begin
      rbase[rcount_r[RangeIdxW-1:0]]  <= in_data.phys_start;
      rbytes[rcount_r[RangeIdxW-1:0]] <= new_bytes;
    end
  end

  // sequencer and result register; the result is cleared once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rcount_r <= '0;
      res_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            ridx_r <= '0;
            cidx_r <= '0;
            case (in_data.operation)
              OP_CLEAR: begin
                rcount_r <= '0;
                state_r  <= S_APPLY;
              end
              OP_ADD: begin
                if (rcount_r >= RangeCntW'(MaxRanges)) begin
                  res_r.status <= ST_FULL;
                end else begin
                  rcount_r <= rcount_r + 1'b1;
                end
                state_r <= S_OUT;
              end
              OP_CREATE: begin
                if (rcount_r == '0) begin
                  res_r.status <= ST_NONE;
                  state_r      <= S_OUT;
                end else begin
                  state_r <= S_RSCAN;
                end
              end
              OP_DELETE, OP_FIND: begin
                if (rcount_r == '0) begin
                  res_r.status <= ST_NONE;
                  state_r      <= S_OUT;
                end else begin
                  state_r <= S_CSCAN;
                end
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_RSCAN: begin
          if (range_hit) begin
            if (cells[MaxMappings-1].valid) begin
              res_r.status <= ST_FULL;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_APPLY;
            end
          end else if (last_range) begin
            res_r.status <= ST_NONE;
            state_r      <= S_OUT;
          end else begin
            ridx_r <= ridx_r + 1'b1;
          end
        end
        S_CSCAN: begin
          if (cell_hit) begin
            if (item_r.operation == OP_FIND) begin
              res_r.found_range_base      <= cur_base;
              res_r.found_virtual_address <= cur_cell.vaddr;
              res_r.found_bytes           <= cur_cell.bytes;
              state_r                     <= S_OUT;
            end else begin
              state_r <= S_APPLY;
            end
          end else if (last_cell || !cur_cell.valid) begin
            cidx_r <= '0;
            if (last_range) begin
              res_r.status <= ST_NONE;
              state_r      <= S_OUT;
            end else begin
              ridx_r <= ridx_r + 1'b1;
            end
          end else begin
            cidx_r <= cidx_r + 1'b1;
          end
        end
        S_APPLY: state_r <= S_OUT;
        S_OUT: begin
          if (!out_stall) begin
            res_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
